### sv/qvr_pkg.sv
// qvr_pkg: shared widths and the pipeline enable struct of the quaternion rotator.
// Used by qvr_coef, qvr_mac and quaternion_vector_rotate; depends on nothing.
package qvr_pkg;

    // quaternion parts are Q1.x in a fixed 16-bit word
    localparam int QUAT_W = 16;
    // product of two quaternion parts
    localparam int PROD_W = 2 * QUAT_W;
    // matrix term: sum or difference of two products, one guard bit
    localparam int COEF_W = PROD_W + 1;
    // matrix terms per row and rows
    localparam int AXES   = 3;

    // load enables, one per register stage
    typedef struct packed {
        logic s1;   // quaternion products
        logic s2;   // matrix terms
        logic s3;   // term times vector
        logic s4;   // row sum plus rounding offset
        logic s5;   // shift, add base, saturate
    } t_pipe_en;

endpackage

### sv/qvr_coef.sv
// qvr_coef: stages 1 and 2, quaternion products and the nine rotation matrix terms.
// Depends on qvr_pkg. Terms have the identity removed and are halved (scale 2^(2F)).
module qvr_coef (
    input  logic                                   i_clk,
    input  qvr_pkg::t_pipe_en                      i_en,
    input  logic signed [qvr_pkg::QUAT_W-1:0]      i_a,
    input  logic signed [qvr_pkg::QUAT_W-1:0]      i_b,
    input  logic signed [qvr_pkg::QUAT_W-1:0]      i_c,
    input  logic signed [qvr_pkg::QUAT_W-1:0]      i_d,
    output logic signed [qvr_pkg::COEF_W-1:0]      o_coef [qvr_pkg::AXES*qvr_pkg::AXES]
);

    logic signed [qvr_pkg::PROD_W-1:0] r_bb, r_cc, r_dd, r_bc, r_ad, r_bd, r_ac, r_cd, r_ab;
    logic signed [qvr_pkg::COEF_W-1:0] r_coef [qvr_pkg::AXES*qvr_pkg::AXES];

    // stage 1: the nine distinct products
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_bb <= i_b * i_b;
            r_cc <= i_c * i_c;
            r_dd <= i_d * i_d;
            r_bc <= i_b * i_c;
            r_ad <= i_a * i_d;
            r_bd <= i_b * i_d;
            r_ac <= i_a * i_c;
            r_cd <= i_c * i_d;
            r_ab <= i_a * i_b;
        end
    end

    // stage 2: matrix terms, row major
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_coef[0] <= -(qvr_pkg::COEF_W'(r_cc) + qvr_pkg::COEF_W'(r_dd));
            r_coef[1] <= qvr_pkg::COEF_W'(r_bc) - qvr_pkg::COEF_W'(r_ad);
            r_coef[2] <= qvr_pkg::COEF_W'(r_bd) + qvr_pkg::COEF_W'(r_ac);
            r_coef[3] <= qvr_pkg::COEF_W'(r_bc) + qvr_pkg::COEF_W'(r_ad);
            r_coef[4] <= -(qvr_pkg::COEF_W'(r_bb) + qvr_pkg::COEF_W'(r_dd));
            r_coef[5] <= qvr_pkg::COEF_W'(r_cd) - qvr_pkg::COEF_W'(r_ab);
            r_coef[6] <= qvr_pkg::COEF_W'(r_bd) - qvr_pkg::COEF_W'(r_ac);
            r_coef[7] <= qvr_pkg::COEF_W'(r_cd) + qvr_pkg::COEF_W'(r_ab);
            r_coef[8] <= -(qvr_pkg::COEF_W'(r_bb) + qvr_pkg::COEF_W'(r_cc));
        end
    end

    assign o_coef = r_coef;

endmodule

### sv/qvr_mac.sv
// qvr_mac: stages 3 to 5 for one output axis: three products, rounded sum, saturation.
// Depends on qvr_pkg. Result = base + floor((sum + 2^(R-1)) / 2^R), R = 2*FRAC_BITS-1.
module qvr_mac #(
    parameter int VEC_WIDTH = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic                                   i_clk,
    input  qvr_pkg::t_pipe_en                      i_en,
    input  logic signed [qvr_pkg::COEF_W-1:0]      i_coef [qvr_pkg::AXES],
    input  logic signed [VEC_WIDTH-1:0]            i_vec  [qvr_pkg::AXES],
    input  logic signed [VEC_WIDTH-1:0]            i_base,
    output logic signed [VEC_WIDTH-1:0]            o_rot,
    output logic                                   o_sat
);

    localparam int RSH   = 2 * FRAC_BITS - 1;
    localparam int PW    = qvr_pkg::COEF_W + VEC_WIDTH;
    // room for three products, and for the rounding offset at any shift
    localparam int ACC_W = (PW + 2 > RSH + 1) ? PW + 2 : RSH + 2;
    localparam int TW    = ACC_W + 1;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (RSH - 1);

    logic signed [PW-1:0]        r_p [qvr_pkg::AXES];
    logic signed [VEC_WIDTH-1:0] r_base3, r_base4;
    logic signed [ACC_W-1:0]     r_sum;
    logic signed [VEC_WIDTH-1:0] r_rot;
    logic                        r_sat;
    logic signed [TW-1:0]        n_total;
    logic                        n_ovf;

    // stage 3: term times vector component
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            for (int n = 0; n < qvr_pkg::AXES; n++) begin
                r_p[n] <= PW'(i_coef[n]) * PW'(i_vec[n]);
            end
            r_base3 <= i_base;
        end
    end

    // stage 4: exact row sum with the half-LSB offset
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_sum   <= ACC_W'(r_p[0]) + ACC_W'(r_p[1]) + ACC_W'(r_p[2]) + HALF;
            r_base4 <= r_base3;
        end
    end

    // floor shift, add the diagonal identity term, check the range
    always_comb begin
        n_total = TW'(r_sum >>> RSH) + TW'(r_base4);
        n_ovf   = !((&n_total[TW-1:VEC_WIDTH-1]) || !(|n_total[TW-1:VEC_WIDTH-1]));
    end

    // stage 5: saturated result
    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_sat <= n_ovf;
            if (n_ovf) begin
                r_rot <= {n_total[TW-1], {(VEC_WIDTH-1){~n_total[TW-1]}}};
            end else begin
                r_rot <= n_total[VEC_WIDTH-1:0];
            end
        end
    end

    assign o_rot = r_rot;
    assign o_sat = r_sat;

endmodule

### sv/quaternion_vector_rotate.sv
// quaternion_vector_rotate: rotates a 3-vector by a quaternion's rotation matrix.
// Depends on qvr_pkg, qvr_coef and qvr_mac.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  input   | i_valid / o_stall  | i_quat_real, i_quat_i, i_quat_j, i_quat_k, i_vec_x/y/z
//  output  | o_valid / i_stall  | o_rot_x, o_rot_y, o_rot_z, o_saturated
//
// Five register stages: products, matrix terms, term x vector, row sum, saturate.
// One transfer per cycle in each direction unless a stall holds it.
// Reset (i_rst_n low at a clock edge) clears the stage valid bits only.
// A stall holds only the stages that are full; empty stages keep filling, so
// o_stall rises only when all five stages hold an item and i_stall is high.
module quaternion_vector_rotate #(
    parameter int VEC_WIDTH = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [qvr_pkg::QUAT_W-1:0]   i_quat_real,
    input  logic signed [qvr_pkg::QUAT_W-1:0]   i_quat_i,
    input  logic signed [qvr_pkg::QUAT_W-1:0]   i_quat_j,
    input  logic signed [qvr_pkg::QUAT_W-1:0]   i_quat_k,
    input  logic signed [VEC_WIDTH-1:0]         i_vec_x,
    input  logic signed [VEC_WIDTH-1:0]         i_vec_y,
    input  logic signed [VEC_WIDTH-1:0]         i_vec_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [VEC_WIDTH-1:0]         o_rot_x,
    output logic signed [VEC_WIDTH-1:0]         o_rot_y,
    output logic signed [VEC_WIDTH-1:0]         o_rot_z,
    output logic                                o_saturated
);

    localparam int NSTG = 5;

    logic [NSTG:1]               r_v;
    logic [NSTG:1]               n_rdy;
    qvr_pkg::t_pipe_en           n_en;
    logic signed [VEC_WIDTH-1:0] r_vec1 [qvr_pkg::AXES];
    logic signed [VEC_WIDTH-1:0] r_vec2 [qvr_pkg::AXES];
    logic signed [qvr_pkg::COEF_W-1:0] w_coef [qvr_pkg::AXES*qvr_pkg::AXES];
    logic signed [qvr_pkg::COEF_W-1:0] w_row0 [qvr_pkg::AXES];
    logic signed [qvr_pkg::COEF_W-1:0] w_row1 [qvr_pkg::AXES];
    logic signed [qvr_pkg::COEF_W-1:0] w_row2 [qvr_pkg::AXES];
    logic [qvr_pkg::AXES-1:0]    w_sat;

    // a stage can load when it is empty or its item moves on this cycle
    always_comb begin
        n_rdy[NSTG] = !r_v[NSTG] || !i_stall;
        for (int k = NSTG - 1; k >= 1; k--) begin
            n_rdy[k] = !r_v[k] || n_rdy[k+1];
        end
        n_en.s1 = n_rdy[1];
        n_en.s2 = n_rdy[2];
        n_en.s3 = n_rdy[3];
        n_en.s4 = n_rdy[4];
        n_en.s5 = n_rdy[5];
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_rdy[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (n_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // vector follows the coefficient stages
    always_ff @(posedge i_clk) begin
        if (n_en.s1) begin
            r_vec1[0] <= i_vec_x;
            r_vec1[1] <= i_vec_y;
            r_vec1[2] <= i_vec_z;
        end
        if (n_en.s2) begin
            r_vec2 <= r_vec1;
        end
    end

    qvr_coef u_coef (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_a    (i_quat_real),
        .i_b    (i_quat_i),
        .i_c    (i_quat_j),
        .i_d    (i_quat_k),
        .o_coef (w_coef)
    );

    // split the matrix into rows
    always_comb begin
        for (int n = 0; n < qvr_pkg::AXES; n++) begin
            w_row0[n] = w_coef[n];
            w_row1[n] = w_coef[qvr_pkg::AXES + n];
            w_row2[n] = w_coef[2*qvr_pkg::AXES + n];
        end
    end

    qvr_mac #(.VEC_WIDTH(VEC_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mac_x (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_coef (w_row0),
        .i_vec  (r_vec2),
        .i_base (r_vec2[0]),
        .o_rot  (o_rot_x),
        .o_sat  (w_sat[0])
    );

    qvr_mac #(.VEC_WIDTH(VEC_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mac_y (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_coef (w_row1),
        .i_vec  (r_vec2),
        .i_base (r_vec2[1]),
        .o_rot  (o_rot_y),
        .o_sat  (w_sat[1])
    );

    qvr_mac #(.VEC_WIDTH(VEC_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mac_z (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_coef (w_row2),
        .i_vec  (r_vec2),
        .i_base (r_vec2[2]),
        .o_rot  (o_rot_z),
        .o_sat  (w_sat[2])
    );

    assign o_saturated = |w_sat;
    assign o_valid     = r_v[NSTG];
    assign o_stall     = !n_rdy[1];

`ifndef SYNTHESIS
    // an accepted transfer lands in stage 1
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v[1])
        else $error("accepted input missing from stage 1");

    // backpressure only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_v) && i_stall)
        else $error("input stalled with a bubble in the pipeline");

    // an item in stage 4 moves to the output when it can
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] && n_rdy[5] |=> r_v[5])
        else $error("item lost between stage 4 and output");

    // an empty output stage never blocks the pipe
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NSTG] |-> n_rdy[1])
        else $error("pipeline blocked while output stage empty");
`endif

endmodule
